FILE: design/mpid_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpid_pkg
// Shared widths, register indexes and stage control types of the
// multichannel positional PID unit.
// ----------------------------------------------------------------------------
package mpid_pkg;

	localparam int CHANNELS_DEF = 4;
	localparam int CH_W         = 2;
	localparam int SAMPLE_W     = 16;
	localparam int GAIN_W       = 16;
	localparam int MASK_W       = 4;
	localparam int ERR_W        = 17;
	localparam int DERR_W       = 18;
	localparam int ACC_W        = 32;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 16;
	localparam int FRAC_BITS    = 8;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN_P = 2'd0,
		REG_GAIN_I = 2'd1,
		REG_GAIN_D = 2'd2,
		REG_ENABLE = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic            valid;
		logic            en;
		logic            in_range;
		logic [CH_W-1:0] ch;
	} ctl_t;

	typedef struct packed {
		logic                    en;
		logic [CH_W-1:0]         ch;
		logic signed [ACC_W-1:0] integ;
		logic signed [ERR_W-1:0] err;
	} loop_wr_t;

	typedef struct packed {
		logic                    en;
		logic [CH_W-1:0]         ch;
		logic signed [ACC_W-1:0] drive;
	} drive_wr_t;

endpackage
`default_nettype wire

FILE: design/mpid_state.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpid_state
// Per-channel integral, last error and drive registers with two read
// selections and two write ports.
// ----------------------------------------------------------------------------
module mpid_state #(
	parameter int CHANNELS = mpid_pkg::CHANNELS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic [mpid_pkg::CH_W-1:0]         rd_a_ch,
	output logic signed [mpid_pkg::ACC_W-1:0]      integ_rd,
	output logic signed [mpid_pkg::ERR_W-1:0]      last_err_rd,
	input  wire logic [mpid_pkg::CH_W-1:0]         rd_b_ch,
	output logic signed [mpid_pkg::ACC_W-1:0]      drive_rd,
	input  wire mpid_pkg::loop_wr_t                loop_wr,
	input  wire mpid_pkg::drive_wr_t               drive_wr
);
	import mpid_pkg::*;

	logic signed [ACC_W-1:0] integ_q    [CHANNELS];
	logic signed [ERR_W-1:0] last_err_q [CHANNELS];
	logic signed [ACC_W-1:0] drive_q    [CHANNELS];

	always_comb begin
		integ_rd    = '0;
		last_err_rd = '0;
		drive_rd    = '0;
		for (int c = 0; c < CHANNELS; c++) begin
			if (32'(rd_a_ch) == c) begin
				integ_rd    = integ_q[c];
				last_err_rd = last_err_q[c];
			end
			if (32'(rd_b_ch) == c) begin
				drive_rd = drive_q[c];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CHANNELS; c++) begin
				integ_q[c]    <= '0;
				last_err_q[c] <= '0;
				drive_q[c]    <= '0;
			end
		end else begin
			for (int c = 0; c < CHANNELS; c++) begin
				if (loop_wr.en && 32'(loop_wr.ch) == c) begin
					integ_q[c]    <= loop_wr.integ;
					last_err_q[c] <= loop_wr.err;
				end
				if (drive_wr.en && 32'(drive_wr.ch) == c) begin
					drive_q[c] <= drive_wr.drive;
				end
			end
		end
	end

endmodule
`default_nettype wire

FILE: design/mpid_math.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpid_math
// Gain multiplies into a product register, then the sum, the scaling
// shift and the saturation to 32 bits.
// ----------------------------------------------------------------------------
module mpid_math (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              adv,
	input  wire logic signed [mpid_pkg::GAIN_W-1:0] kp,
	input  wire logic signed [mpid_pkg::GAIN_W-1:0] ki,
	input  wire logic signed [mpid_pkg::GAIN_W-1:0] kd,
	input  wire mpid_pkg::ctl_t                    ctl_s2,
	input  wire logic signed [mpid_pkg::ERR_W-1:0]  err_s2,
	input  wire logic signed [mpid_pkg::ACC_W-1:0]  integ_s2,
	input  wire logic signed [mpid_pkg::DERR_W-1:0] derr_s2,
	output mpid_pkg::ctl_t                         ctl_s3,
	output logic signed [mpid_pkg::ERR_W-1:0]      err_s3,
	output logic signed [mpid_pkg::ACC_W-1:0]      integ_s3,
	output logic signed [mpid_pkg::ACC_W-1:0]      drive_calc
);
	import mpid_pkg::*;

	localparam int PP_W  = GAIN_W + ERR_W;
	localparam int PI_W  = GAIN_W + ACC_W;
	localparam int PD_W  = GAIN_W + DERR_W;
	localparam int SUM_W = PI_W + 1;

	logic signed [PP_W-1:0]  pp_s3;
	logic signed [PI_W-1:0]  pi_s3;
	logic signed [PD_W-1:0]  pd_s3;
	logic signed [SUM_W-1:0] sum;
	logic signed [SUM_W-1:0] scaled;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3 <= '0;
		end else if (adv) begin
			ctl_s3 <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pp_s3    <= PP_W'(kp) * PP_W'(err_s2);
			pi_s3    <= PI_W'(ki) * PI_W'(integ_s2);
			pd_s3    <= PD_W'(kd) * PD_W'(derr_s2);
			err_s3   <= err_s2;
			integ_s3 <= integ_s2;
		end
	end

	// The arithmetic shift rounds toward minus infinity.
	always_comb begin
		sum    = SUM_W'(pp_s3) + SUM_W'(pi_s3) + SUM_W'(pd_s3);
		scaled = sum >>> FRAC_BITS;
		if (scaled[SUM_W-1:ACC_W-1] == '0 || scaled[SUM_W-1:ACC_W-1] == '1) begin
			drive_calc = scaled[ACC_W-1:0];
		end else if (scaled[SUM_W-1]) begin
			drive_calc = {1'b1, {(ACC_W-1){1'b0}}};
		end else begin
			drive_calc = {1'b0, {(ACC_W-1){1'b1}}};
		end
	end

endmodule
`default_nettype wire

FILE: design/multichannel_positional_pid_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multichannel_positional_pid_unit
// Positional PID controller shared by several channels, with Q8.8 gains
// common to all channels and per-channel integral, last error and drive.
//
//   Channel   Handshake             Payload
//   input     in_valid / in_ready   channel, setpoint, measured
//   output    out_valid / out_ready drive, error_now, integral_now, ran
//   config    wr_en                 wr_index, wr_data
//
// One item per cycle while results are taken. The result is registered once the
// accepted transfer has passed the input register, the error and integral
// register, the product register and the result register.
// A channel's integral and last error are written as the item leaves the input
// register, so consecutive items on one channel chain without gaps. Reset
// clears gains, mask and all channel state at once. The whole pipeline holds
// while a result waits to be taken.
// ----------------------------------------------------------------------------
module multichannel_positional_pid_unit #(
	parameter int CHANNELS = mpid_pkg::CHANNELS_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  in_valid,
	output logic                                       in_ready,
	input  wire logic [mpid_pkg::CH_W-1:0]             channel,
	input  wire logic signed [mpid_pkg::SAMPLE_W-1:0]  setpoint,
	input  wire logic signed [mpid_pkg::SAMPLE_W-1:0]  measured,
	output logic                                       out_valid,
	input  wire logic                                  out_ready,
	output logic signed [mpid_pkg::ACC_W-1:0]          drive,
	output logic signed [mpid_pkg::ERR_W-1:0]          error_now,
	output logic signed [mpid_pkg::ACC_W-1:0]          integral_now,
	output logic                                       ran,
	input  wire logic                                  wr_en,
	input  wire logic [mpid_pkg::CFG_IDX_W-1:0]        wr_index,
	input  wire logic [mpid_pkg::CFG_DATA_W-1:0]       wr_data
);
	import mpid_pkg::*;

	logic signed [GAIN_W-1:0] kp_q;
	logic signed [GAIN_W-1:0] ki_q;
	logic signed [GAIN_W-1:0] kd_q;
	logic [MASK_W-1:0]        mask_q;

	logic                       adv;
	logic                       v_s1;
	logic [CH_W-1:0]            ch_s1;
	logic signed [SAMPLE_W-1:0] sp_s1;
	logic signed [SAMPLE_W-1:0] ms_s1;
	ctl_t                       ctl_s1;

	logic signed [ACC_W-1:0]  integ_rd;
	logic signed [ERR_W-1:0]  last_err_rd;
	logic signed [ACC_W-1:0]  drive_rd;
	logic signed [ERR_W-1:0]  err_a;
	logic signed [ACC_W:0]    isum_a;
	logic signed [ACC_W-1:0]  isat_a;
	logic signed [ACC_W-1:0]  integ_a;
	logic signed [DERR_W-1:0] derr_a;
	loop_wr_t                 loop_wr;
	drive_wr_t                drive_wr;

	ctl_t                     ctl_s2;
	logic signed [ERR_W-1:0]  err_s2;
	logic signed [ACC_W-1:0]  integ_s2;
	logic signed [DERR_W-1:0] derr_s2;

	ctl_t                     ctl_s3;
	logic signed [ERR_W-1:0]  err_s3;
	logic signed [ACC_W-1:0]  integ_s3;
	logic signed [ACC_W-1:0]  drive_calc;

	logic                     out_valid_q;
	logic signed [ACC_W-1:0]  drive_q;
	logic signed [ERR_W-1:0]  error_q;
	logic signed [ACC_W-1:0]  integral_q;
	logic                     ran_q;

	assign adv      = !out_valid_q || out_ready;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q   <= '0;
			ki_q   <= '0;
			kd_q   <= '0;
			mask_q <= '0;
		end else if (wr_en) begin
			unique case (reg_idx_t'(wr_index))
				REG_GAIN_P: kp_q   <= wr_data[GAIN_W-1:0];
				REG_GAIN_I: ki_q   <= wr_data[GAIN_W-1:0];
				REG_GAIN_D: kd_q   <= wr_data[GAIN_W-1:0];
				REG_ENABLE: mask_q <= wr_data[MASK_W-1:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && in_valid) begin
			ch_s1 <= channel;
			sp_s1 <= setpoint;
			ms_s1 <= measured;
		end
	end

	always_comb begin
		ctl_s1.valid    = v_s1;
		ctl_s1.ch       = ch_s1;
		ctl_s1.in_range = 32'(ch_s1) < CHANNELS;
		ctl_s1.en       = ctl_s1.in_range && mask_q[ch_s1];
	end

	mpid_state #(
		.CHANNELS(CHANNELS)
	) u_state (
		.clk        (clk),
		.arst_n     (arst_n),
		.rd_a_ch    (ch_s1),
		.integ_rd   (integ_rd),
		.last_err_rd(last_err_rd),
		.rd_b_ch    (ctl_s3.ch),
		.drive_rd   (drive_rd),
		.loop_wr    (loop_wr),
		.drive_wr   (drive_wr)
	);

	always_comb begin
		err_a  = ERR_W'(sp_s1) - ERR_W'(ms_s1);
		isum_a = (ACC_W+1)'(integ_rd) + (ACC_W+1)'(err_a);
		if (isum_a[ACC_W] == isum_a[ACC_W-1]) begin
			isat_a = isum_a[ACC_W-1:0];
		end else if (isum_a[ACC_W]) begin
			isat_a = {1'b1, {(ACC_W-1){1'b0}}};
		end else begin
			isat_a = {1'b0, {(ACC_W-1){1'b1}}};
		end
		derr_a = DERR_W'(err_a) - DERR_W'(last_err_rd);
		if (ctl_s1.en) begin
			integ_a = isat_a;
		end else if (ctl_s1.in_range) begin
			integ_a = integ_rd;
		end else begin
			integ_a = '0;
		end
		loop_wr.en    = adv && ctl_s1.valid && ctl_s1.en;
		loop_wr.ch    = ch_s1;
		loop_wr.integ = isat_a;
		loop_wr.err   = err_a;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (adv) begin
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			err_s2   <= err_a;
			integ_s2 <= integ_a;
			derr_s2  <= derr_a;
		end
	end

	mpid_math u_math (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.kp        (kp_q),
		.ki        (ki_q),
		.kd        (kd_q),
		.ctl_s2    (ctl_s2),
		.err_s2    (err_s2),
		.integ_s2  (integ_s2),
		.derr_s2   (derr_s2),
		.ctl_s3    (ctl_s3),
		.err_s3    (err_s3),
		.integ_s3  (integ_s3),
		.drive_calc(drive_calc)
	);

	always_comb begin
		drive_wr.en    = adv && ctl_s3.valid && ctl_s3.en;
		drive_wr.ch    = ctl_s3.ch;
		drive_wr.drive = drive_calc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= ctl_s3.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && ctl_s3.valid) begin
			integral_q <= integ_s3;
			ran_q      <= ctl_s3.en;
			if (ctl_s3.en) begin
				drive_q <= drive_calc;
				error_q <= err_s3;
			end else begin
				drive_q <= ctl_s3.in_range ? drive_rd : '0;
				error_q <= '0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign drive        = drive_q;
	assign error_now    = error_q;
	assign integral_now = integral_q;
	assign ran          = ran_q;

	a_in_to_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> v_s1)
		else $error("accepted transfer did not reach the input register");

	a_s3_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv && ctl_s3.valid |=> out_valid)
		else $error("finished item did not reach the result register");

	a_idle_error: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !ran |-> error_now == '0)
		else $error("idle channel reported a nonzero error");

	a_hold_state: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |-> !loop_wr.en && !drive_wr.en)
		else $error("channel state written while the pipeline holds");

endmodule
`default_nettype wire

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the multichannel positional PID unit. A local
// fixed-point PID computes the result of every accepted sample from its own
// copy of the gains, enable mask and channel state. Each result transfer is
// compared field by field against the oldest pending prediction. Directed
// tests cover reset state, gain and sample extremes, disabled channels and
// drive saturation. Random phases then run with random gains, masks and
// handshake idling, including one long output hold.
// ----------------------------------------------------------------------------
module tb_top;
	import mpid_pkg::*;

	localparam int NCH         = CHANNELS_DEF;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int IDLE_PCT    = 36;
	localparam int HOLD_CYCLES = 400;
	localparam int SAT_STEPS   = 300;

	typedef struct {
		logic signed [ACC_W-1:0] drive;
		logic signed [ERR_W-1:0] err;
		logic signed [ACC_W-1:0] integ;
		logic                    ran;
	} pid_result_t;

	logic                       clk       = 1'b0;
	logic                       arst_n    = 1'b0;
	logic                       in_valid  = 1'b0;
	logic                       in_ready;
	logic [CH_W-1:0]            channel   = '0;
	logic signed [SAMPLE_W-1:0] setpoint  = '0;
	logic signed [SAMPLE_W-1:0] measured  = '0;
	logic                       out_valid;
	logic                       out_ready = 1'b0;
	logic signed [ACC_W-1:0]    drive;
	logic signed [ERR_W-1:0]    error_now;
	logic signed [ACC_W-1:0]    integral_now;
	logic                       ran;
	logic                       wr_en     = 1'b0;
	reg_idx_t                   wr_index  = REG_GAIN_P;
	logic [CFG_DATA_W-1:0]      wr_data   = '0;

	logic signed [GAIN_W-1:0] kp_model   = '0;
	logic signed [GAIN_W-1:0] ki_model   = '0;
	logic signed [GAIN_W-1:0] kd_model   = '0;
	logic [MASK_W-1:0]        mask_model = '0;
	logic signed [ACC_W-1:0]  integral_mem [NCH] = '{default: '0};
	logic signed [ERR_W-1:0]  last_err_mem [NCH] = '{default: '0};
	logic signed [ACC_W-1:0]  drive_mem    [NCH] = '{default: '0};

	pid_result_t pid_results_q [$];
	int          error_count   = 0;
	int          cycle_count   = 0;
	bit          calm          = 1'b0;
	int          hold_requests = 0;
	int          hold_served   = 0;
	int          hold_left     = 0;

	multichannel_positional_pid_unit #(
		.CHANNELS(NCH)
	) u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.channel     (channel),
		.setpoint    (setpoint),
		.measured    (measured),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.drive       (drive),
		.error_now   (error_now),
		.integral_now(integral_now),
		.ran         (ran),
		.wr_en       (wr_en),
		.wr_index    (wr_index),
		.wr_data     (wr_data)
	);

	always #5 clk = ~clk;

	function automatic longint clamp32(input longint v);
		if (v > 64'sd2147483647) begin
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			return -64'sd2147483648;
		end
		return v;
	endfunction

	function automatic pid_result_t pid_step(input logic [CH_W-1:0] ch,
			input logic signed [SAMPLE_W-1:0] sp, input logic signed [SAMPLE_W-1:0] ms);
		pid_result_t r;
		longint      e;
		longint      acc;
		longint      sum;
		if (!mask_model[ch]) begin
			r.drive = drive_mem[ch];
			r.err   = '0;
			r.integ = integral_mem[ch];
			r.ran   = 1'b0;
			return r;
		end
		e   = longint'(sp) - longint'(ms);
		acc = clamp32(longint'(integral_mem[ch]) + e);
		sum = longint'(kp_model) * e + longint'(ki_model) * acc
			+ longint'(kd_model) * (e - longint'(last_err_mem[ch]));
		r.drive = ACC_W'(clamp32(sum >>> FRAC_BITS));
		r.err   = ERR_W'(e);
		r.integ = ACC_W'(acc);
		r.ran   = 1'b1;
		integral_mem[ch] = r.integ;
		last_err_mem[ch] = r.err;
		drive_mem[ch]    = r.drive;
		return r;
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(7))
			0: begin
				return 16'sh7FFF;
			end
			1: begin
				return 16'sh8000;
			end
			2, 3: begin
				return SAMPLE_W'($urandom);
			end
			default: begin
				return SAMPLE_W'($urandom_range(4000) - 2000);
			end
		endcase
	endfunction

	function automatic logic signed [GAIN_W-1:0] pick_gain();
		case ($urandom_range(5))
			0: begin
				return 16'sh7FFF;
			end
			1: begin
				return 16'sh8000;
			end
			2: begin
				return '0;
			end
			3: begin
				return GAIN_W'($urandom);
			end
			default: begin
				return GAIN_W'($urandom_range(4096) - 2048);
			end
		endcase
	endfunction

	always @(posedge clk) begin
		if (wr_en) begin
			case (wr_index)
				REG_GAIN_P: begin
					kp_model = wr_data;
				end
				REG_GAIN_I: begin
					ki_model = wr_data;
				end
				REG_GAIN_D: begin
					kd_model = wr_data;
				end
				REG_ENABLE: begin
					mask_model = wr_data[MASK_W-1:0];
				end
				default: begin
				end
			endcase
		end
		if (in_valid && in_ready) begin
			pid_results_q.push_back(pid_step(channel, setpoint, measured));
		end
	end

	always @(posedge clk) begin : check_result
		pid_result_t want;
		if (out_valid && out_ready) begin
			if (pid_results_q.size() == 0) begin
				$error("result transfer with no pending prediction");
				error_count++;
			end else begin
				want = pid_results_q.pop_front();
				if (drive !== want.drive) begin
					$error("drive: expected %0d, actual %0d", want.drive, drive);
					error_count++;
				end
				if (error_now !== want.err) begin
					$error("error_now: expected %0d, actual %0d", want.err, error_now);
					error_count++;
				end
				if (integral_now !== want.integ) begin
					$error("integral_now: expected %0d, actual %0d", want.integ, integral_now);
					error_count++;
				end
				if (ran !== want.ran) begin
					$error("ran: expected %0d, actual %0d", want.ran, ran);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else if (hold_served != hold_requests) begin
			hold_served <= hold_served + 1;
			hold_left   <= HOLD_CYCLES;
			out_ready   <= 1'b0;
		end else begin
			out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic send_sample(input logic [CH_W-1:0] ch, input logic signed [SAMPLE_W-1:0] sp,
			input logic signed [SAMPLE_W-1:0] ms);
		int gap;
		gap = 0;
		if (!calm) begin
			while ($urandom_range(99) < IDLE_PCT) begin
				gap++;
			end
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		channel  <= ch;
		setpoint <= sp;
		measured <= ms;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_ready !== 1'b1);
	endtask

	task automatic drain_pipeline();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pid_results_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= data;
		@(posedge clk);
	endtask

	task automatic set_gains(input logic signed [GAIN_W-1:0] kp, input logic signed [GAIN_W-1:0] ki,
			input logic signed [GAIN_W-1:0] kd, input logic [MASK_W-1:0] mask);
		drain_pipeline();
		write_reg(REG_GAIN_P, kp);
		write_reg(REG_GAIN_I, ki);
		write_reg(REG_GAIN_D, kd);
		write_reg(REG_ENABLE, {(CFG_DATA_W-MASK_W)'($urandom), mask});
		wr_en <= 1'b0;
	endtask

	task automatic test_reset_defaults();
		for (int ch = 0; ch < NCH; ch++) begin
			send_sample(CH_W'(ch), 16'sh7FFF, 16'sh8000);
		end
	endtask

	task automatic test_proportional_extremes();
		set_gains(16'sh7FFF, '0, '0, 4'hF);
		send_sample(2'd0, 16'sh7FFF, 16'sh8000);
		send_sample(2'd1, 16'sh8000, 16'sh7FFF);
		send_sample(2'd2, '0, '0);
		set_gains(16'sh8000, '0, '0, 4'hF);
		send_sample(2'd3, 16'sh7FFF, 16'sh8000);
		send_sample(2'd0, 16'sh8000, 16'sh7FFF);
	endtask

	task automatic test_mixed_terms();
		set_gains(16'sd256, 16'sh8000, 16'sh7FFF, 4'b0101);
		send_sample(2'd0, 16'sd100, -16'sd50);
		send_sample(2'd1, 16'sd5, 16'sd6);
		send_sample(2'd2, 16'sh8000, 16'sh8000);
		send_sample(2'd0, -16'sd1, '0);
		send_sample(2'd3, 16'sh7FFF, '0);
	endtask

	task automatic test_disabled_hold();
		set_gains(16'sd1000, 16'sd2000, -16'sd3000, 4'b1010);
		send_sample(2'd1, 16'sd1234, -16'sd4321);
		send_sample(2'd3, -16'sd20000, 16'sd100);
		send_sample(2'd1, 16'sd300, 16'sd301);
		set_gains(16'sd1000, 16'sd2000, -16'sd3000, 4'b0000);
		for (int ch = 0; ch < NCH; ch++) begin
			send_sample(CH_W'(ch), 16'sd777, -16'sd777);
		end
		set_gains(16'sd1000, 16'sd2000, -16'sd3000, 4'hF);
		send_sample(2'd1, 16'sd10, 16'sd20);
	endtask

	task automatic test_drive_saturation();
		set_gains(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 4'b0011);
		calm <= 1'b1;
		repeat (SAT_STEPS) begin
			send_sample(2'd0, 16'sh7FFF, 16'sh8000);
			send_sample(2'd1, 16'sh8000, 16'sh7FFF);
		end
		set_gains(16'sh7FFF, 16'sh8000, 16'sh7FFF, 4'b0011);
		repeat (3) begin
			send_sample(2'd0, 16'sh7FFF, 16'sh8000);
			send_sample(2'd1, 16'sh8000, 16'sh7FFF);
		end
		repeat (2) begin
			send_sample(2'd0, 16'sh8000, 16'sh7FFF);
			send_sample(2'd1, 16'sh7FFF, 16'sh8000);
		end
		calm <= 1'b0;
	endtask

	task automatic test_random_phases();
		logic [MASK_W-1:0] mask;
		for (int phase = 0; phase < 8; phase++) begin
			mask = MASK_W'($urandom);
			case (phase)
				0: begin
					set_gains(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 4'hF);
				end
				1: begin
					set_gains(16'sh8000, 16'sh8000, 16'sh8000, 4'hF);
				end
				2: begin
					set_gains('0, '0, '0, 4'h0);
				end
				default: begin
					set_gains(pick_gain(), pick_gain(), pick_gain(), mask);
				end
			endcase
			calm <= (phase == 5);
			if (phase == 3) begin
				hold_requests <= hold_requests + 1;
			end
			repeat (80) begin
				send_sample(CH_W'($urandom), pick_sample(), pick_sample());
			end
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_proportional_extremes();
		test_mixed_terms();
		test_disabled_hold();
		test_drive_saturation();
		test_random_phases();
		drain_pipeline();
		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

FILE: filelist.f
design/mpid_pkg.sv
design/mpid_state.sv
design/mpid_math.sv
design/multichannel_positional_pid_unit.sv
verif/tb_top.sv
